// ===== sv/a64dp_pkg.sv =====
package a64dp_pkg;

  typedef enum logic [5:0] {
    MN_ADR, MN_ADRP, MN_ADD, MN_ADDS, MN_SUB, MN_SUBS, MN_ADDG, MN_SUBG,
    MN_AND, MN_ORR, MN_EOR, MN_ANDS, MN_MOVN, MN_MOVZ, MN_MOVK, MN_SBFM,
    MN_BFM, MN_UBFM, MN_EXTR, MN_RBIT, MN_REV16, MN_REV, MN_REV32, MN_CLZ,
    MN_CLS, MN_SUBPS, MN_SUBP, MN_UDIV, MN_SDIV, MN_IRG, MN_GMI, MN_LSLV,
    MN_LSRV, MN_ASRV, MN_RORV, MN_PACGA, MN_CRC32B, MN_CRC32H, MN_CRC32W,
    MN_CRC32X, MN_CRC32CB, MN_CRC32CH, MN_CRC32CW, MN_CRC32CX, MN_ADC,
    MN_ADCS, MN_SBC, MN_SBCS, MN_RMIF, MN_SETF8, MN_SETF16, MN_CCMN, MN_CCMP,
    MN_CSEL, MN_CSINC, MN_CSINV, MN_CSNEG, MN_BIC, MN_ORN, MN_EON, MN_BICS
  } mnem_t;

  typedef struct packed {
    logic        ok;
    logic [5:0]  mn;
    logic        wd;
    logic [4:0]  d;
    logic [4:0]  a;
    logic [4:0]  b;
    logic [63:0] imm;
    logic [5:0]  im2;
    logic [1:0]  shk;
    logic [2:0]  exk;
    logic [3:0]  cc;
  } dec_t;

  // bitmask-immediate request: element size decided, pattern built later
  typedef struct packed {
    logic       req;
    logic       ok;
    logic       wd;
    logic [6:0] esz;
    logic [5:0] sv;
    logic [5:0] rv;
  } bm_t;

  localparam logic [3:0] CLS_IMM_MASK = 4'b1110;
  localparam logic [3:0] CLS_IMM      = 4'b1000;
  localparam logic [3:0] SETF_NZCV    = 4'b1101;

endpackage

// ===== sv/a64dp_decode.sv =====
module a64dp_decode
  import a64dp_pkg::*;
(
  input  logic [31:0] w,
  output dec_t        dec,
  output bm_t         bm
);

  logic       sfb, opb, sb, b22;
  logic [1:0] opc;
  logic [5:0] immr, imms, sub;
  logic [3:0] grp, cls;
  logic [4:0] rmv;
  logic [6:0] v;
  logic [2:0] top;
  logic [5:0] lv;
  logic [1:0] csz;

  always_comb begin
    sfb  = w[31];
    opb  = w[30];
    sb   = w[29];
    opc  = w[30:29];
    b22  = w[22];
    immr = w[21:16];
    imms = w[15:10];
    sub  = w[15:10];
    grp  = w[24:21];
    rmv  = w[20:16];
    cls  = w[28:25];
    dec  = '0;
    bm   = '0;
    v    = {b22, ~imms};
    top  = 3'd0;
    for (int i = 1; i <= 6; i++) begin
      if (v[i]) top = 3'(i);
    end
    lv   = 6'((7'd1 << top) - 7'd1);
    csz  = sub[1:0];
    dec.d  = w[4:0];
    dec.a  = w[9:5];
    dec.wd = sfb;
    if ((cls & CLS_IMM_MASK) == CLS_IMM) begin
      dec.ok = 1'b1;
      unique case (w[25:23])
        3'd0, 3'd1: begin
          dec.mn  = sfb ? MN_ADRP : MN_ADR;
          dec.wd  = 1'b1;
          dec.a   = '0;
          dec.imm = {{43{w[23]}}, w[23:5], w[30:29]};
        end
        3'd2: begin
          dec.mn  = 6'(MN_ADD) + 6'(opc);
          dec.imm = 64'(w[21:10]);
          dec.im2 = b22 ? 6'd12 : 6'd0;
        end
        3'd3: begin
          dec.ok  = !sb && sfb;
          dec.mn  = opb ? MN_SUBG : MN_ADDG;
          dec.imm = 64'(immr);
          dec.im2 = 6'(w[13:10]);
        end
        3'd4: begin
          dec.ok = !(!sfb && b22) && top != 3'd0 && (imms & lv) != lv;
          dec.mn = 6'(MN_AND) + 6'(opc);
          bm.req = 1'b1;
          bm.wd  = sfb;
          bm.esz = 7'd1 << top;
          bm.sv  = imms & lv;
          bm.rv  = immr & lv;
        end
        3'd5: begin
          dec.ok  = !(opc == 2'd1 || (!sfb && b22));
          dec.mn  = (opc == 2'd0) ? MN_MOVN : ((opc == 2'd2) ? MN_MOVZ : MN_MOVK);
          dec.a   = '0;
          dec.imm = 64'(w[20:5]);
          dec.im2 = {w[22:21], 4'd0};
        end
        3'd6: begin
          dec.ok  = !(opc == 2'd3 || sfb != b22);
          dec.mn  = 6'(MN_SBFM) + 6'(opc);
          dec.imm = 64'(immr);
          dec.im2 = imms;
        end
        default: begin
          dec.ok  = !(sfb != b22 || opc != 2'd0 || w[21] || (!sfb && imms[5]));
          dec.mn  = MN_EXTR;
          dec.b   = rmv;
          dec.im2 = imms;
        end
      endcase
    end else if (cls[2:0] == 3'd5) begin
      dec.b = rmv;
      if (!w[28]) begin
        dec.ok  = 1'b1;
        dec.im2 = sub;
        if (!grp[3]) begin
          dec.ok = !(!sfb && sub[5]);
          unique case ({opc, w[21]})
            3'd0: dec.mn = MN_AND;
            3'd1: dec.mn = MN_BIC;
            3'd2: dec.mn = MN_ORR;
            3'd3: dec.mn = MN_ORN;
            3'd4: dec.mn = MN_EOR;
            3'd5: dec.mn = MN_EON;
            3'd6: dec.mn = MN_ANDS;
            default: dec.mn = MN_BICS;
          endcase
          dec.shk = w[23:22];
        end else if (!grp[0]) begin
          dec.ok  = !((!sfb && sub[5]) || w[23:22] == 2'd3);
          dec.mn  = 6'(MN_ADD) + 6'(opc);
          dec.shk = w[23:22];
        end else begin
          dec.ok  = w[23:22] == 2'd0;
          dec.mn  = 6'(MN_ADD) + 6'(opc);
          dec.exk = w[15:13];
          dec.im2 = 6'(w[12:10]);
        end
      end else if (grp == 4'd6) begin
        if (opb) begin
          dec.b  = '0;
          dec.ok = rmv == 5'd0 && !sb;
          unique case (sub)
            6'd0: dec.mn = MN_RBIT;
            6'd1: dec.mn = MN_REV16;
            6'd2: dec.mn = sfb ? MN_REV32 : MN_REV;
            6'd3: begin dec.mn = MN_REV; if (!sfb) dec.ok = 1'b0; end
            6'd4: dec.mn = MN_CLZ;
            6'd5: dec.mn = MN_CLS;
            default: dec.ok = 1'b0;
          endcase
        end else if (sb) begin
          dec.ok = sfb && sub == 6'd0;
          dec.mn = MN_SUBPS;
        end else begin
          dec.ok = 1'b1;
          unique case (sub)
            6'd0: begin dec.mn = MN_SUBP; dec.ok = sfb; end
            6'd2: dec.mn = MN_UDIV;
            6'd3: dec.mn = MN_SDIV;
            6'd4: begin dec.mn = MN_IRG; dec.ok = sfb; end
            6'd5: begin dec.mn = MN_GMI; dec.ok = sfb; end
            6'd8, 6'd9, 6'd10, 6'd11: dec.mn = 6'(MN_LSLV) + 6'(sub[1:0]);
            6'd12: begin dec.mn = MN_PACGA; dec.ok = sfb; end
            default: begin
              dec.ok = sub[5:3] == 3'b010 && (sfb == (csz == 2'd3));
              dec.mn = 6'(MN_CRC32B) + {3'd0, sub[2], csz};
            end
          endcase
        end
      end else if (grp == 4'd0) begin
        if (sub == 6'd0) begin
          dec.ok = 1'b1;
          dec.mn = 6'(MN_ADC) + 6'(opc);
        end else if (sub[4:0] == 5'd1) begin
          dec.ok  = opc == 2'd1 && sfb && !w[4];
          dec.mn  = MN_RMIF;
          dec.d   = '0;
          dec.b   = '0;
          dec.imm = 64'(w[20:15]);
          dec.im2 = 6'(w[3:0]);
        end else if (sub[3:0] == 4'd2) begin
          dec.ok = !sfb && opc == 2'd1 && w[20:15] == 6'd0 && !w[4]
                   && w[3:0] == SETF_NZCV;
          dec.mn = w[14] ? MN_SETF16 : MN_SETF8;
          dec.d  = '0;
          dec.b  = '0;
        end
      end else if (grp == 4'd2) begin
        dec.ok  = !w[4] && !w[10] && sb;
        dec.mn  = opb ? MN_CCMP : MN_CCMN;
        dec.d   = '0;
        dec.imm = 64'(w[11]);
        dec.im2 = 6'(w[3:0]);
        dec.cc  = w[15:12];
      end else if (grp == 4'd4) begin
        dec.ok = !sb && !w[11];
        dec.mn = 6'(MN_CSEL) + {4'd0, opb, w[10]};
        dec.cc = w[15:12];
      end
    end
    if (!dec.ok) begin
      dec = '0;
      bm  = '0;
    end
  end

endmodule

// ===== sv/a64dp_bitmask.sv =====
module a64dp_bitmask
  import a64dp_pkg::*;
(
  input  bm_t         bm,
  output logic [63:0] pat
);

  logic [63:0] ones, rot, emask;

  // ones, rotate inside element, replicate to 64 bits
  always_comb begin
    ones  = ~64'd0 >> (6'd63 - bm.sv);
    emask = (bm.esz == 7'd64) ? ~64'd0 : ~(~64'd0 << bm.esz);
    rot   = ones;
    if (bm.rv != 6'd0) begin
      rot = ((ones >> bm.rv) | (ones << (bm.esz - 7'(bm.rv)))) & emask;
    end
    pat = rot;
    for (int k = 0; k < 6; k++) begin
      if (bm.esz <= 7'(1 << k)) pat = pat | (pat << (1 << k));
    end
    if (!bm.wd) pat[63:32] = '0;
  end

endmodule

// ===== sv/a64_data_processing_decoder.sv =====
// An accepted item passes the stage registers in order to the outputs.
// Throughput: one item per cycle unless out_ready stalls; stage 1 decodes
// fields, stage 2 expands the logical-immediate bitmask, stage 3 is the
// output register. A stall holds each full stage whose next stage is held;
// empty stages still fill, and nothing is dropped or repeated.
// Reset: synchronous, active high; clears all stage valid bits.
module a64_data_processing_decoder
  import a64dp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instr_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        valid_res,
  output logic [5:0]  mnemonic,
  output logic        wide,
  output logic [4:0]  dest_reg,
  output logic [4:0]  src_reg_a,
  output logic [4:0]  src_reg_b,
  output logic [63:0] imm_value,
  output logic [5:0]  imm_second,
  output logic [1:0]  shift_kind,
  output logic [2:0]  extend_kind,
  output logic [3:0]  cond_code
);

  logic        v0, v1, v2;
  dec_t        d1, d2, d3, d2_next, dec_c;
  bm_t         b1, bm_c;
  logic [63:0] pat_c;
  logic        adv0, adv1, adv2;

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign adv0     = !v0 || adv1;
  assign in_ready = adv0;

  a64dp_decode u_dec (.w({instr_word[7:0], instr_word[15:8], instr_word[23:16],
                          instr_word[31:24]}), .dec(dec_c), .bm(bm_c));
  a64dp_bitmask u_bm (.bm(b1), .pat(pat_c));

  always_comb begin
    d2_next = d1;
    if (b1.req) d2_next.imm = pat_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv0) v0 <= in_valid;
      if (adv1) v1 <= v0;
      if (adv2) v2 <= v1;
    end
    if (adv0 && in_valid) begin
      d1 <= dec_c;
      b1 <= bm_c;
    end
    if (adv1 && v0) d2 <= d2_next;
    if (adv2 && v1) d3 <= d2;
  end

  always_comb begin
    valid_res   = d3.ok;
    mnemonic    = d3.mn;
    wide        = d3.wd;
    dest_reg    = d3.d;
    src_reg_a   = d3.a;
    src_reg_b   = d3.b;
    imm_value   = d3.imm;
    imm_second  = d3.im2;
    shift_kind  = d3.shk;
    extend_kind = d3.exk;
    cond_code   = d3.cc;
    out_valid   = v2;
  end

endmodule

// ===== test/a64dp_checker.sv =====
module a64dp_checker
  import a64dp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] instr_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        valid_res,
  input  logic [5:0]  mnemonic,
  input  logic        wide,
  input  logic [4:0]  dest_reg,
  input  logic [4:0]  src_reg_a,
  input  logic [4:0]  src_reg_b,
  input  logic [63:0] imm_value,
  input  logic [5:0]  imm_second,
  input  logic [1:0]  shift_kind,
  input  logic [2:0]  extend_kind,
  input  logic [3:0]  cond_code,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  dec_t decode_q[$];

  function automatic logic expand_mask(input logic nbit, input logic [5:0] rot,
                                       input logic [5:0] ones, output logic [63:0] pat);
    logic [6:0] v;
    int top;
    int esz;
    logic [5:0] lv, sv, rv;
    logic [63:0] p;
    v = {nbit, ~ones};
    top = -1;
    for (int i = 6; i >= 0; i--)
      if (v[i] && top < 0) top = i;
    pat = '0;
    if (top < 1) return 1'b0;
    esz = 1 << top;
    lv = 6'(esz - 1);
    sv = ones & lv;
    rv = rot & lv;
    if (sv == lv) return 1'b0;
    p = {64{1'b1}} >> (63 - sv);
    if (rv != 0) begin
      p = (p >> rv) | (p << (esz - rv));
      if (esz < 64) p &= {64{1'b1}} >> (64 - esz);
    end
    while (esz < 64) begin
      p |= p << esz;
      esz *= 2;
    end
    pat = p;
    return 1'b1;
  endfunction

  function automatic logic dec_imm(input logic [31:0] w, inout dec_t r);
    logic sfb, opb, sb, b22;
    logic [1:0] opc;
    logic [5:0] immr, imms;
    logic [20:0] v;
    logic [63:0] pat;
    sfb = w[31]; opb = w[30]; sb = w[29]; opc = w[30:29]; b22 = w[22];
    immr = w[21:16]; imms = w[15:10];
    r.d = w[4:0]; r.a = w[9:5]; r.wd = sfb;
    case (w[25:23])
      3'd0, 3'd1: begin
        v = {w[23:5], w[30:29]};
        r.mn = sfb ? MN_ADRP : MN_ADR;
        r.wd = 1; r.a = 0;
        r.imm = {{43{v[20]}}, v};
        return 1;
      end
      3'd2: begin
        r.mn = MN_ADD + opc;
        r.imm = 64'(w[21:10]);
        r.im2 = b22 ? 6'd12 : 6'd0;
        return 1;
      end
      3'd3: begin
        if (sb || !sfb) return 0;
        r.mn = opb ? MN_SUBG : MN_ADDG;
        r.imm = 64'(immr);
        r.im2 = 6'(w[13:10]);
        return 1;
      end
      3'd4: begin
        if (!sfb && b22) return 0;
        if (!expand_mask(b22, immr, imms, pat)) return 0;
        if (!sfb) pat[63:32] = '0;
        r.mn = MN_AND + opc;
        r.imm = pat;
        return 1;
      end
      3'd5: begin
        if (opc == 1 || (!sfb && b22)) return 0;
        r.mn = opc == 0 ? MN_MOVN : (opc == 2 ? MN_MOVZ : MN_MOVK);
        r.a = 0;
        r.imm = 64'(w[20:5]);
        r.im2 = 6'(w[22:21]) * 6'd16;
        return 1;
      end
      3'd6: begin
        if (opc == 3 || sfb != b22) return 0;
        r.mn = MN_SBFM + opc;
        r.imm = 64'(immr);
        r.im2 = imms;
        return 1;
      end
      default: begin
        if (sfb != b22 || opc != 0 || w[21] || (!sfb && imms[5])) return 0;
        r.mn = MN_EXTR;
        r.b = w[20:16];
        r.im2 = imms;
        return 1;
      end
    endcase
  endfunction

  function automatic logic dec_reg(input logic [31:0] w, inout dec_t r);
    logic sfb, opb, sb;
    logic [1:0] opc, shk, csz;
    logic [3:0] grp;
    logic [5:0] sub;
    mnem_t lcode[8];
    lcode = '{MN_AND, MN_BIC, MN_ORR, MN_ORN, MN_EOR, MN_EON, MN_ANDS, MN_BICS};
    sfb = w[31]; opb = w[30]; sb = w[29]; opc = w[30:29];
    grp = w[24:21]; sub = w[15:10];
    r.d = w[4:0]; r.a = w[9:5]; r.b = w[20:16]; r.wd = sfb;
    if (!w[28]) begin
      shk = w[23:22];
      r.im2 = sub;
      if (!grp[3]) begin
        if (!sfb && sub[5]) return 0;
        r.mn = lcode[{opc, w[21]}];
        r.shk = shk;
      end else if (!grp[0]) begin
        if ((!sfb && sub[5]) || shk == 3) return 0;
        r.mn = MN_ADD + opc;
        r.shk = shk;
      end else begin
        if (shk != 0) return 0;
        r.mn = MN_ADD + opc;
        r.exk = w[15:13];
        r.im2 = 6'(w[12:10]);
      end
      return 1;
    end
    if (grp == 6) begin
      if (opb) begin
        if (w[20:16] != 0 || sb) return 0;
        r.b = 0;
        case (sub)
          0: r.mn = MN_RBIT;
          1: r.mn = MN_REV16;
          2: r.mn = sfb ? MN_REV32 : MN_REV;
          3: begin if (!sfb) return 0; r.mn = MN_REV; end
          4: r.mn = MN_CLZ;
          5: r.mn = MN_CLS;
          default: return 0;
        endcase
        return 1;
      end
      if (sb) begin
        if (!sfb || sub != 0) return 0;
        r.mn = MN_SUBPS;
        return 1;
      end
      case (sub)
        0: begin if (!sfb) return 0; r.mn = MN_SUBP; end
        2: r.mn = MN_UDIV;
        3: r.mn = MN_SDIV;
        4: begin if (!sfb) return 0; r.mn = MN_IRG; end
        5: begin if (!sfb) return 0; r.mn = MN_GMI; end
        8, 9, 10, 11: r.mn = 6'(MN_LSLV + (sub - 8));
        12: begin if (!sfb) return 0; r.mn = MN_PACGA; end
        default: begin
          if (sub[5:3] != 3'b010) return 0;
          csz = sub[1:0];
          if ((sfb && csz != 3) || (!sfb && csz == 3)) return 0;
          r.mn = 6'(MN_CRC32B + sub[2] * 4 + csz);
        end
      endcase
      return 1;
    end
    if (grp == 0) begin
      if (sub == 0) begin
        r.mn = MN_ADC + opc;
        return 1;
      end
      if (sub[4:0] == 1) begin
        if (opc != 1 || !sfb || w[4]) return 0;
        r.mn = MN_RMIF;
        r.d = 0; r.b = 0;
        r.imm = 64'(w[20:15]);
        r.im2 = 6'(w[3:0]);
        return 1;
      end
      if (sub[3:0] == 2) begin
        if (sfb || opc != 1 || w[20:15] != 0 || w[4] || w[3:0] != SETF_NZCV) return 0;
        r.mn = w[14] ? MN_SETF16 : MN_SETF8;
        r.d = 0; r.b = 0;
        return 1;
      end
      return 0;
    end
    if (grp == 2) begin
      if (w[4] || w[10] || !sb) return 0;
      r.mn = opb ? MN_CCMP : MN_CCMN;
      r.d = 0;
      r.imm = 64'(w[11]);
      r.im2 = 6'(w[3:0]);
      r.cc = w[15:12];
      return 1;
    end
    if (grp == 4) begin
      if (sb || w[11]) return 0;
      r.mn = 6'(MN_CSEL + opb * 2 + w[10]);
      r.cc = w[15:12];
      return 1;
    end
    return 0;
  endfunction

  function automatic dec_t decode_word(input logic [31:0] raw);
    logic [31:0] w;
    dec_t r;
    logic ok;
    w = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
    r = '0;
    ok = 0;
    if ((w[28:25] & CLS_IMM_MASK) == CLS_IMM) ok = dec_imm(w, r);
    else if (w[27:25] == 3'b101) ok = dec_reg(w, r);
    if (!ok) r = '0;
    r.ok = ok;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("error %0t: %s got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    dec_t e;
    if (rst) begin
      fail_count = 0;
      decode_q.delete();
    end else begin
      if (in_valid && in_ready) decode_q.push_back(decode_word(instr_word));
      if (out_valid && out_ready) begin
        if (decode_q.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          e = decode_q.pop_front();
          if (valid_res !== e.ok) report_mismatch("valid_res", valid_res, e.ok);
          if (mnemonic !== e.mn) report_mismatch("mnemonic", mnemonic, e.mn);
          if (wide !== e.wd) report_mismatch("wide", wide, e.wd);
          if (dest_reg !== e.d) report_mismatch("dest_reg", dest_reg, e.d);
          if (src_reg_a !== e.a) report_mismatch("src_reg_a", src_reg_a, e.a);
          if (src_reg_b !== e.b) report_mismatch("src_reg_b", src_reg_b, e.b);
          if (imm_value !== e.imm) report_mismatch("imm_value", imm_value, e.imm);
          if (imm_second !== e.im2) report_mismatch("imm_second", imm_second, e.im2);
          if (shift_kind !== e.shk) report_mismatch("shift_kind", shift_kind, e.shk);
          if (extend_kind !== e.exk) report_mismatch("extend_kind", extend_kind, e.exk);
          if (cond_code !== e.cc) report_mismatch("cond_code", cond_code, e.cc);
        end
      end
    end
    pending = decode_q.size();
  end
endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;
  localparam int HOLD_LEN = 60;

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [31:0] instr_word;
  logic        valid_res, wide;
  logic [5:0]  mnemonic, imm_second;
  logic [4:0]  dest_reg, src_reg_a, src_reg_b;
  logic [63:0] imm_value;
  logic [1:0]  shift_kind;
  logic [2:0]  extend_kind;
  logic [3:0]  cond_code;
  int          fail_count, pending;
  int          send_idle, recv_stall, hold_cycles, idle_cycles;
  logic        hold_req, hold_done;

  a64_data_processing_decoder dut (.*);
  a64dp_checker chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver: random stalls, or one long hold-off when asked
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 0;
      hold_cycles <= 0;
      hold_done <= 0;
    end else if (hold_req && !hold_done) begin
      out_ready <= 0;
      hold_cycles <= HOLD_LEN - 1;
      hold_done <= 1;
    end else if (hold_cycles > 0) begin
      out_ready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("a64_data_processing_decoder: mismatch");
      $finish;
    end
  end

  // mostly data-processing words, stored byte-swapped as the block reads them
  function automatic logic [31:0] make_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(9))
      0, 1, 2: w[28:26] = 3'b100;
      3, 4, 5: w[27:25] = 3'b101;
      6: begin w[28:21] = 8'b11010110; w[15:14] = 0; end
      7: begin w[28:21] = 8'b11010000; w[15:13] = 0; end
      8: begin w[28:21] = 8'b11010010; w[29] = 1; end
      default: ;
    endcase
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // leaves valid high after the item; the next send drops it while it idles
  task automatic send(input logic [31:0] w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    instr_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] swap(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  task automatic burst(input int n);
    for (int i = 0; i < n; i++) send(make_word());
  endtask

  logic [31:0] directed[] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h10000000, 32'h90000000, 32'h91000000,
    32'hF1400000, 32'h91800000, 32'h92400000, 32'h127F0000, 32'hB27EF3E0,
    32'h93400000, 32'h93C00000, 32'hD2800000, 32'hF2E00000, 32'h52800000,
    32'hDAC00000, 32'h9AC00C00, 32'h9AC04C00, 32'h9AC03000, 32'hBAC00000,
    32'hBA000420, 32'h3A00480D, 32'hFA400800, 32'hDA800400, 32'h8B208C00
  };

  initial begin
    rst = 1; in_valid = 0; instr_word = 0;
    send_idle = 0; recv_stall = 0; hold_req = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    foreach (directed[i]) send(swap(directed[i]));
    burst(400);
    send_idle = 69; burst(300);
    send_idle = 0; recv_stall = 69; burst(300);
    send_idle = 12; recv_stall = 12; burst(300);
    send_idle = 0; recv_stall = 0;
    hold_req = 1;
    burst(150);
    // pause until the pipeline drains
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < 250; i++) send($urandom);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("a64_data_processing_decoder: match");
    else
      $display("a64_data_processing_decoder: mismatch");
    $finish;
  end
endmodule
